// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/sdr_pkg.sv -----
// package: types, constants and control structs of the radial search unit
`default_nettype none
package sdr_pkg;

    localparam int MAX_DIM    = 256;
    localparam int RADIUS_CAP = 64;

    localparam int DIM_W      = 9;
    localparam int RAD_W      = 7;
    localparam int POS_W      = 8;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 2 * POS_W;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OFS_W      = 8;
    localparam int RING_W     = 8;
    localparam int DIST_W     = 14;
    localparam int SQRT_W     = 23;
    localparam int NUM_W      = 31;
    localparam int DIVR_W     = 8;
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS = 2'd2;

    localparam logic [VAL_W-1:0] HALF_Q16 = 32'd32768;
    localparam logic [VAL_W-1:0] MID_Q16  = 32'd8355840;
    localparam logic [VAL_W-1:0] TOP_Q16  = 32'd16711680;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] distance_code;
        logic              out_of_range;
    } out_item_t;

    typedef struct packed {
        logic mem_write;
        logic accept_query;
        logic latch_centre;
        logic ring_init;
        logic ring_next;
        logic scan_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic in_oor;
        logic ring_stop;
        logic ring_last;
        logic sqrt_last;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/sdr_datapath.sv -----
// datapath: config registers, pixel memory, ring scan, square root, scaling divider
`default_nettype none
module sdr_datapath
    import sdr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire in_item_t              in_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output out_item_t                  out_data
);

    logic [DIM_W-1:0]  map_width_reg, map_height_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [DIM_W-1:0]  dim_sat;
    logic [RAD_W-1:0]  rad_sat;

    logic [PIX_W-1:0]  mem [0:(1 << ADDR_W) - 1];
    logic [PIX_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [POS_W-1:0]  cx_reg, cy_reg;
    logic              oor_reg;
    logic [PIX_W-1:0]  centre_reg;

    logic [RING_W-1:0] k_reg;
    logic [OFS_W-1:0]  dx_reg, dy_reg;
    logic [OFS_W-1:0]  neg_k, neg_k1;
    logic              edge_row;
    logic [POS_W+1:0]  px, py;
    logic              in_map;
    logic [2*RING_W-1:0] k_sq;

    logic              pvalid_reg;
    logic [OFS_W-1:0]  pdx_reg, pdy_reg;
    logic signed [2*OFS_W-1:0] sqx, sqy;
    logic [2*OFS_W-1:0] dsum;
    logic [DIST_W-1:0] best_reg;

    logic [SQRT_W-1:0]   s_reg, sbit_reg, trial;
    logic [2*SQRT_W-1:0] trial_sq, n_val;

    logic [NUM_W-1:0]  num, q_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [DIVR_W-1:0] rem_reg, divisor;
    logic [DIVR_W:0]   rem2;
    logic              ge;

    logic [VAL_W-1:0]  v, vsum;
    logic [CODE_W-1:0] code;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    // config saturation
    always_comb
    begin
        if (cfg_data == '0)
            dim_sat = DIM_W'(1);
        else if (cfg_data > CFG_DATA_W'(MAX_DIM))
            dim_sat = DIM_W'(MAX_DIM);
        else
            dim_sat = cfg_data[DIM_W-1:0];
        if (cfg_data[RAD_W-1:0] == '0)
            rad_sat = RAD_W'(1);
        else if (cfg_data[RAD_W-1:0] > RAD_W'(RADIUS_CAP))
            rad_sat = RAD_W'(RADIUS_CAP);
        else
            rad_sat = cfg_data[RAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= DIM_W'(MAX_DIM);
            map_height_reg <= DIM_W'(MAX_DIM);
            radius_reg     <= RAD_W'(32);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH:     map_width_reg  <= dim_sat;
                CFG_MAP_HEIGHT:    map_height_reg <= dim_sat;
                CFG_SEARCH_RADIUS: radius_reg     <= rad_sat;
                default:           ;
            endcase
        end
    end

    // pixel memory
    assign px = {2'b00, cx_reg} + {{2{dx_reg[OFS_W-1]}}, dx_reg};
    assign py = {2'b00, cy_reg} + {{2{dy_reg[OFS_W-1]}}, dy_reg};
    assign in_map = !px[POS_W+1] && !py[POS_W+1]
                    && (px[POS_W:0] < map_width_reg) && (py[POS_W:0] < map_height_reg);
    assign rd_addr = cmd.scan_step ? {py[POS_W-1:0], px[POS_W-1:0]}
                                   : {in_data.pos_y, in_data.pos_x};

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            mem[{in_data.pos_y, in_data.pos_x}] <= in_data.pixel_value;
        rd_data_reg <= mem[rd_addr];
    end

    assign status.in_oor = ({1'b0, in_data.pos_x} >= map_width_reg)
                           || ({1'b0, in_data.pos_y} >= map_height_reg);

    // ring walk
    assign neg_k    = OFS_W'(0) - k_reg;
    assign neg_k1   = OFS_W'(0) - (k_reg + RING_W'(1));
    assign edge_row = (dy_reg == k_reg) || (dy_reg == neg_k);
    assign k_sq     = k_reg * k_reg;
    assign status.ring_last = (dx_reg == k_reg) && (dy_reg == k_reg);
    assign status.ring_stop = (k_reg > {1'b0, radius_reg})
                              || (k_sq >= {{(2*RING_W-DIST_W){1'b0}}, best_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.accept_query)
        begin
            cx_reg  <= in_data.pos_x;
            cy_reg  <= in_data.pos_y;
            oor_reg <= status.in_oor;
        end
        if (cmd.latch_centre)
            centre_reg <= rd_data_reg;
        if (cmd.ring_init)
        begin
            k_reg  <= RING_W'(1);
            dx_reg <= {OFS_W{1'b1}};
            dy_reg <= {OFS_W{1'b1}};
        end
        else if (cmd.ring_next)
        begin
            k_reg  <= k_reg + RING_W'(1);
            dx_reg <= neg_k1;
            dy_reg <= neg_k1;
        end
        else if (cmd.scan_step)
        begin
            if (edge_row)
            begin
                if (dx_reg == k_reg)
                begin
                    dy_reg <= dy_reg + OFS_W'(1);
                    dx_reg <= neg_k;
                end
                else
                    dx_reg <= dx_reg + OFS_W'(1);
            end
            else if (dx_reg == neg_k)
                dx_reg <= k_reg;
            else
            begin
                dy_reg <= dy_reg + OFS_W'(1);
                dx_reg <= neg_k;
            end
        end
        pdx_reg <= dx_reg;
        pdy_reg <= dy_reg;
    end

    // compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvalid_reg <= 1'b0;
        else
            pvalid_reg <= cmd.scan_step & in_map;
    end

    assign sqx  = $signed(pdx_reg) * $signed(pdx_reg);
    assign sqy  = $signed(pdy_reg) * $signed(pdy_reg);
    assign dsum = $unsigned(sqx) + $unsigned(sqy);

    always_ff @(posedge clk)
    begin
        if (cmd.ring_init)
            best_reg <= DIST_W'(radius_reg) * DIST_W'(radius_reg) + DIST_W'(1);
        else if (pvalid_reg && (rd_data_reg != centre_reg)
                 && (dsum[DIST_W-1:0] < best_reg))
            best_reg <= dsum[DIST_W-1:0];
    end

    // square root, one result bit per cycle
    assign trial     = s_reg | sbit_reg;
    assign trial_sq  = trial * trial;
    assign n_val     = {best_reg, 32'd0};
    assign status.sqrt_last = sbit_reg[0];

    // scaling divide by 2R, one quotient bit per cycle
    assign num     = NUM_W'(s_reg) * NUM_W'(255);
    assign divisor = {radius_reg, 1'b0};
    assign rem2    = {rem_reg, num[div_cnt_reg]};
    assign ge      = rem2 >= {1'b0, divisor};
    assign status.div_last = (div_cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            s_reg       <= '0;
            sbit_reg    <= {1'b1, {(SQRT_W-1){1'b0}}};
            div_cnt_reg <= CNT_W'(NUM_W - 1);
            rem_reg     <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (trial_sq <= n_val)
                s_reg <= trial;
            sbit_reg <= sbit_reg >> 1;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= ge ? DIVR_W'(rem2 - {1'b0, divisor}) : rem2[DIVR_W-1:0];
            q_reg       <= {q_reg[NUM_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    // offset, clamp and round
    always_comb
    begin
        vsum = MID_Q16 + {1'b0, q_reg};
        if (centre_reg == '0)
            v = ({1'b0, q_reg} > MID_Q16) ? '0 : MID_Q16 - {1'b0, q_reg};
        else
            v = (vsum > TOP_Q16) ? TOP_Q16 : vsum;
        code = CODE_W'((v + HALF_Q16) >> 16);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.distance_code <= oor_reg ? '0 : code;
            out_data_reg.out_of_range  <= oor_reg;
        end
    end

    assign status.out_free = !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/sdr_ctrl.sv -----
// controller: sequences centre read, ring scan, square root, divide and result
`default_nettype none
module sdr_ctrl
    import sdr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_kind,
    output logic            in_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CENTRE = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_SCAN   = 8'b0000_1000,
        ST_DRAIN  = 8'b0001_0000,
        ST_SQRT   = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == KIND_WRITE)
                        cmd.mem_write = 1'b1;
                    else
                    begin
                        cmd.accept_query = 1'b1;
                        state_next = status.in_oor ? ST_FINISH : ST_CENTRE;
                    end
                end
            end
            ST_CENTRE:
            begin
                cmd.latch_centre = 1'b1;
                cmd.ring_init    = 1'b1;
                state_next       = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.ring_stop)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_SQRT;
                end
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.ring_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.ring_next = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/signed_distance_radial_search_unit.sv -----
// top level of the signed distance radial search unit
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | to unit   | in_valid / in_stall | in_data: kind, pos_x, pos_y, pixel
//  out     | from unit | out_valid/out_stall | out_data: distance_code, oor flag
//  cfg     | to unit   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a pixel write is done in the idle state; an out-of-map query goes straight to the
// result load; an in-map query reads the centre pixel, then scans the 8k pixels of each
// ring k from k = 1 out, checking before each ring whether to stop, then runs the square
// root, the scaling divide and the result load; the single memory read port sets the
// scan length; reset is asynchronous; the pixel memory is not cleared and needs no sweep
// out_stall holds the output register and a pending result in the finish state; input stalls while a query runs
`default_nettype none
module signed_distance_radial_search_unit
    import sdr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sdr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ----- rtl/core/sdr_checker.sv -----
// port checker for the radial search unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sdr_checker
    import sdr_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire in_item_t              in_data,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire out_item_t             out_data
);

    // a stalled result stays
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    // out-of-map results carry a zero code
    `ASSERT_SAME(a_oor_code, out_valid && out_data.out_of_range, out_data.distance_code == '0)
    // a query transfer blocks the input
    `ASSERT_NEXT(a_query_busy, in_valid && !in_stall && in_data.kind == KIND_QUERY, in_stall)

endmodule

bind signed_distance_radial_search_unit sdr_checker u_sdr_checker (.*);
`default_nettype wire
